// ===== src/btr_pkg.sv =====
// Shared constants, types and index helpers for the bilinear tile resampler.
package btr_pkg;

  localparam int MODEL_DIM   = 512;
  localparam int SOURCE_DIM  = 128;
  localparam int MODEL_SCALE = 4;

  localparam int ACT_W      = 2;
  localparam int POS_W      = 9;
  localparam int SAMPLE_W   = 16;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int SCALE_W    = 3;
  localparam int LEN_W      = 10;
  localparam int OFF_W      = 9;

  localparam int NB_W = $clog2(MODEL_DIM);
  localparam int MA_W = $clog2(MODEL_DIM * MODEL_DIM);
  localparam int SA_W = $clog2(SOURCE_DIM * SOURCE_DIM);

  // Model coordinates in sixths of a model pixel.
  localparam int C_W    = 16;
  localparam int FRAC_W = 3;
  localparam int SIXTH  = 6;

  localparam int ONE_Q    = 4096;
  localparam int BYTE_MAX = 255;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE_MODEL = 2'd0,
    ACT_WRITE_ALPHA = 2'd1,
    ACT_READ        = 2'd2
  } btr_action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZOOM         = 3'd0,
    CFG_MODEL_WIDTH  = 3'd1,
    CFG_MODEL_HEIGHT = 3'd2,
    CFG_LEFT_OFFSET  = 3'd3,
    CFG_TOP_OFFSET   = 3'd4
  } btr_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_QEST,
    ST_QFIX,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_HORZ,
    ST_VERT,
    ST_SCALE,
    ST_DIV,
    ST_FIN
  } btr_state_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic load_c;
    logic horz;
    logic vert;
    logic scale;
    logic div;
  } btr_step_t;

  function automatic logic [MA_W-1:0] model_index(input logic [NB_W-1:0] row,
                                                  input logic [NB_W-1:0] col);
    return MA_W'(int'(row) * MODEL_DIM + int'(col));
  endfunction

  function automatic logic [SA_W-1:0] source_index(input logic [POS_W-1:0] row,
                                                   input logic [POS_W-1:0] col);
    return SA_W'(int'(row) * SOURCE_DIM + int'(col));
  endfunction

endpackage

// ===== src/btr_if.sv =====
// Handshake channels of the resampler: configuration, command and pixel result.
interface btr_cfg_if;
  import btr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface btr_cmd_if;
  import btr_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [ACT_W-1:0]           action;
  logic [POS_W-1:0]           pos_x;
  logic [POS_W-1:0]           pos_y;
  logic signed [SAMPLE_W-1:0] red_in;
  logic signed [SAMPLE_W-1:0] green_in;
  logic signed [SAMPLE_W-1:0] blue_in;
  logic [BYTE_W-1:0]          alpha_in;

  modport source (output valid, action, pos_x, pos_y, red_in, green_in, blue_in, alpha_in,
                  input ready);
  modport sink (input valid, action, pos_x, pos_y, red_in, green_in, blue_in, alpha_in,
                output ready);
endinterface

interface btr_pix_if;
  import btr_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] red_out;
  logic [BYTE_W-1:0] green_out;
  logic [BYTE_W-1:0] blue_out;
  logic [BYTE_W-1:0] alpha_out;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

// ===== src/bilinear_tile_resampler.sv =====
// Top level: sample memories, coordinate mapping, read sequencer and result register.
//
// The block holds a model tile (red, green, blue, signed Q4.12 at four times the
// source resolution) in one single-port memory of MODEL_DIM*MODEL_DIM entries, and
// source alpha bytes in a second single-port memory of SOURCE_DIM*SOURCE_DIM
// entries. A write-model or write-alpha command stores one entry; the command
// port is ready again on the next cycle. A read command maps output pixel (x,y)
// to model coordinates in sixths, fetches the four neighbors one per cycle from
// the model memory, blends them horizontally then vertically, and scales, rounds
// and clamps each channel to a byte; alpha comes from the nearest source pixel.
// A read occupies the block from the command transfer to the result entering
// the output register: coordinate mapping (clamp, divide by six, correct), the
// four accesses of the single model memory port, blend and rounding arithmetic
// (horizontal, vertical, scale, divide), and a final step that loads the result. The
// command port reopens on the cycle after the load, so no new read transfers
// before the last one is through. If the previous result has not been taken,
// the read holds in its last step until the output register frees. Memory
// contents are undefined until written; reading an unwritten entry gives an
// unspecified value and no clearing pass runs after reset. Write configuration
// only while no read is in flight.
module bilinear_tile_resampler (
  input logic     clk,
  input logic     rst,
  btr_cfg_if.sink cfg,
  btr_cmd_if.sink cmd,
  btr_pix_if.source pix
);
  import btr_pkg::*;

  localparam int MID_SCALE  = 3;
  localparam logic [SCALE_W-1:0] SCALE_LO  = SCALE_W'(2);
  localparam logic [SCALE_W-1:0] SCALE_MID = SCALE_W'(MID_SCALE);
  localparam logic [SCALE_W-1:0] SCALE_HI  = SCALE_W'(4);
  localparam int RESET_LEN  = 512;
  localparam int SPAN       = SIXTH * MODEL_SCALE;
  localparam int HALF_SPAN  = SPAN / 2;
  localparam int HALF_SIXTH = SIXTH / 2;
  localparam int COORD_MULT = MODEL_SCALE / 4;
  localparam int DIV6_SHIFT = 16;
  localparam int DIV6_RECIP = (1 << DIV6_SHIFT) / SIXTH;
  localparam int P6_W       = C_W + DIV6_SHIFT;
  localparam int DIV3_SHIFT = 10;
  localparam int DIV3_RECIP = (1 << DIV3_SHIFT) / MID_SCALE;
  localparam int P3_W       = POS_W + DIV3_SHIFT;
  localparam int MW         = 3 * SAMPLE_W;

  // Configuration registers
  logic [SCALE_W-1:0] zoom;
  logic [LEN_W-1:0]   model_width;
  logic [LEN_W-1:0]   model_height;
  logic [OFF_W-1:0]   left_offset;
  logic [OFF_W-1:0]   top_offset;

  // Sequencer and per-read working registers
  btr_state_t        state, state_next;
  logic [POS_W-1:0]  px, py;
  logic [C_W-1:0]    cx, cy;
  logic [NB_W-1:0]   qx_est, qy_est;
  logic [NB_W-1:0]   x0, x1, y0, y1;
  logic [FRAC_W-1:0] fx, fy;
  logic [POS_W-1:0]  sx_est, sy_est, sx, sy;
  logic              alpha_ok;

  // Memories
  logic [MW-1:0]     model_mem [MODEL_DIM * MODEL_DIM];
  logic [MW-1:0]     model_rd;
  logic [BYTE_W-1:0] alpha_mem [SOURCE_DIM * SOURCE_DIM];
  logic [BYTE_W-1:0] alpha_rd;

  // Result register
  logic              out_valid;
  logic [BYTE_W-1:0] out_red, out_green, out_blue, out_alpha;

  // Combinational signals
  logic              cfg_xfer, cmd_xfer;
  logic [SCALE_W-1:0] scale_eff;
  logic [NB_W-1:0]   last_x, last_y;
  logic [C_W-1:0]    cx_raw, cy_raw, hi_x, hi_y;
  logic [P6_W-1:0]   prod6x, prod6y;
  logic [C_W-1:0]    remx, remy;
  logic [NB_W-1:0]   x0_next, y0_next;
  logic [FRAC_W-1:0] fx_next, fy_next;
  logic [P3_W-1:0]   prod3x, prod3y;
  logic [POS_W-1:0]  sx_div, sy_div, rem3x, rem3y, sx_fix, sy_fix;
  logic              model_we, model_re, alpha_we, alpha_re;
  logic [MA_W-1:0]   model_wa, model_ra;
  logic [SA_W-1:0]   alpha_wa, alpha_ra;
  btr_step_t         step;
  logic              out_load;
  logic [BYTE_W-1:0] red_val, green_val, blue_val;

  function automatic logic [NB_W-1:0] eff_last(input logic [LEN_W-1:0] len);
    if (len == '0) return '0;
    if (int'(len) > MODEL_DIM) return NB_W'(MODEL_DIM - 1);
    return NB_W'(int'(len) - 1);
  endfunction

  // Center-aligned mapping: 6*offset + (SPAN*pos + SPAN/2)/scale - 1/2 pixel.
  // The lowest value is zero, so only the upper edge needs a clamp.
  function automatic logic [C_W-1:0] axis_coord(input logic [POS_W-1:0] pos,
                                                input logic [OFF_W-1:0] off,
                                                input logic [SCALE_W-1:0] scale);
    int term;
    case (scale)
      SCALE_LO:  term = (SPAN / 2) * int'(pos) + HALF_SPAN / 2;
      SCALE_MID: term = (SPAN / MID_SCALE) * int'(pos) + HALF_SPAN / MID_SCALE;
      default:   term = (SPAN / 4) * int'(pos) + HALF_SPAN / 4;
    endcase
    return C_W'(SIXTH * int'(off) + COORD_MULT * term - HALF_SIXTH);
  endfunction

  assign cfg_xfer  = cfg.valid && cfg.ready;
  assign cmd_xfer  = cmd.valid && cmd.ready;
  assign cfg.ready = 1'b1;
  assign cmd.ready = (state == ST_IDLE);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      zoom         <= SCALE_HI;
      model_width  <= LEN_W'(RESET_LEN);
      model_height <= LEN_W'(RESET_LEN);
      left_offset  <= '0;
      top_offset   <= '0;
    end else if (cfg_xfer) begin
      case (cfg.index)
        CFG_ZOOM:         zoom         <= cfg.data[SCALE_W-1:0];
        CFG_MODEL_WIDTH:  model_width  <= cfg.data[LEN_W-1:0];
        CFG_MODEL_HEIGHT: model_height <= cfg.data[LEN_W-1:0];
        CFG_LEFT_OFFSET:  left_offset  <= cfg.data[OFF_W-1:0];
        CFG_TOP_OFFSET:   top_offset   <= cfg.data[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective scale and tile extent
  always_comb begin
    if (zoom < SCALE_LO) scale_eff = SCALE_LO;
    else if (zoom > SCALE_HI) scale_eff = SCALE_HI;
    else scale_eff = zoom;
  end

  assign last_x = eff_last(model_width);
  assign last_y = eff_last(model_height);
  assign hi_x   = C_W'(SIXTH * int'(last_x));
  assign hi_y   = C_W'(SIXTH * int'(last_y));
  assign cx_raw = axis_coord(px, left_offset, scale_eff);
  assign cy_raw = axis_coord(py, top_offset, scale_eff);

  // Divide by six: reciprocal estimate, then one correction step
  assign prod6x  = P6_W'(cx) * P6_W'(DIV6_RECIP);
  assign prod6y  = P6_W'(cy) * P6_W'(DIV6_RECIP);
  assign remx    = cx - C_W'(SIXTH * int'(qx_est));
  assign remy    = cy - C_W'(SIXTH * int'(qy_est));
  assign x0_next = (remx >= C_W'(SIXTH)) ? qx_est + 1'b1 : qx_est;
  assign y0_next = (remy >= C_W'(SIXTH)) ? qy_est + 1'b1 : qy_est;
  assign fx_next = (remx >= C_W'(SIXTH)) ? FRAC_W'(remx - C_W'(SIXTH)) : FRAC_W'(remx);
  assign fy_next = (remy >= C_W'(SIXTH)) ? FRAC_W'(remy - C_W'(SIXTH)) : FRAC_W'(remy);

  // Source pixel for alpha: shift for scales two and four, reciprocal for three
  assign prod3x = P3_W'(px) * P3_W'(DIV3_RECIP);
  assign prod3y = P3_W'(py) * P3_W'(DIV3_RECIP);

  always_comb begin
    case (scale_eff)
      SCALE_LO: begin
        sx_div = px >> 1;
        sy_div = py >> 1;
      end
      SCALE_MID: begin
        sx_div = prod3x[DIV3_SHIFT +: POS_W];
        sy_div = prod3y[DIV3_SHIFT +: POS_W];
      end
      default: begin
        sx_div = px >> 2;
        sy_div = py >> 2;
      end
    endcase
  end

  assign rem3x  = px - POS_W'(MID_SCALE * int'(sx_est));
  assign rem3y  = py - POS_W'(MID_SCALE * int'(sy_est));
  assign sx_fix = (scale_eff == SCALE_MID && rem3x >= POS_W'(MID_SCALE)) ?
                  sx_est + 1'b1 : sx_est;
  assign sy_fix = (scale_eff == SCALE_MID && rem3y >= POS_W'(MID_SCALE)) ?
                  sy_est + 1'b1 : sy_est;

  // Per-read working registers, advanced by the sequencer state
  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      px <= cmd.pos_x;
      py <= cmd.pos_y;
    end
    if (state == ST_CLAMP) begin
      cx     <= (cx_raw > hi_x) ? hi_x : cx_raw;
      cy     <= (cy_raw > hi_y) ? hi_y : cy_raw;
      sx_est <= sx_div;
      sy_est <= sy_div;
    end
    if (state == ST_QEST) begin
      qx_est   <= prod6x[DIV6_SHIFT +: NB_W];
      qy_est   <= prod6y[DIV6_SHIFT +: NB_W];
      sx       <= sx_fix;
      sy       <= sy_fix;
      alpha_ok <= (int'(sx_fix) < SOURCE_DIM) && (int'(sy_fix) < SOURCE_DIM);
    end
    if (state == ST_QFIX) begin
      x0 <= x0_next;
      y0 <= y0_next;
      fx <= fx_next;
      fy <= fy_next;
    end
    // Second neighbor: one step on, held at the tile edge
    if (state == ST_RD0) begin
      x1 <= (x0 < last_x) ? x0 + 1'b1 : last_x;
      y1 <= (y0 < last_y) ? y0 + 1'b1 : last_y;
    end
  end

  // Write ports come from the command channel; out-of-range writes drop
  assign model_we = cmd_xfer && (cmd.action == ACT_WRITE_MODEL) &&
                    (int'(cmd.pos_x) < MODEL_DIM) && (int'(cmd.pos_y) < MODEL_DIM);
  assign model_wa = model_index(NB_W'(cmd.pos_y), NB_W'(cmd.pos_x));
  assign alpha_we = cmd_xfer && (cmd.action == ACT_WRITE_ALPHA) &&
                    (int'(cmd.pos_x) < SOURCE_DIM) && (int'(cmd.pos_y) < SOURCE_DIM);
  assign alpha_wa = source_index(cmd.pos_y, cmd.pos_x);
  assign alpha_ra = source_index(sy, sx);

  // Single-port memories; writes only land while idle, so reads never collide
  always_ff @(posedge clk) begin
    if (model_we) model_mem[model_wa] <= {cmd.red_in, cmd.green_in, cmd.blue_in};
    else if (model_re) model_rd <= model_mem[model_ra];
  end

  always_ff @(posedge clk) begin
    if (alpha_we) alpha_mem[alpha_wa] <= cmd.alpha_in;
    else if (alpha_re) alpha_rd <= alpha_mem[alpha_ra];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (cmd_xfer && cmd.action == ACT_READ) state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_QEST;
      ST_QEST:  state_next = ST_QFIX;
      ST_QFIX:  state_next = ST_RD0;
      ST_RD0:   state_next = ST_RD1;
      ST_RD1:   state_next = ST_RD2;
      ST_RD2:   state_next = ST_RD3;
      ST_RD3:   state_next = ST_HORZ;
      ST_HORZ:  state_next = ST_VERT;
      ST_VERT:  state_next = ST_SCALE;
      ST_SCALE: state_next = ST_DIV;
      ST_DIV:   state_next = ST_FIN;
      ST_FIN:   if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Each read state issues one neighbor address; each after the first latches the one fetched before
  always_comb begin
    step     = '0;
    model_re = 1'b0;
    model_ra = model_index(y0, x0);
    alpha_re = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_QFIX: alpha_re = alpha_ok;
      ST_RD0:  model_re = 1'b1;
      ST_RD1: begin
        model_re    = 1'b1;
        model_ra    = model_index(y0, x1);
        step.load_a = 1'b1;
      end
      ST_RD2: begin
        model_re    = 1'b1;
        model_ra    = model_index(y1, x0);
        step.load_b = 1'b1;
      end
      ST_RD3: begin
        model_re    = 1'b1;
        model_ra    = model_index(y1, x1);
        step.load_c = 1'b1;
      end
      ST_HORZ:  step.horz  = 1'b1;
      ST_VERT:  step.vert  = 1'b1;
      ST_SCALE: step.scale = 1'b1;
      ST_DIV:   step.div   = 1'b1;
      ST_FIN:   out_load   = !out_valid || pix.ready;
      default: ;
    endcase
  end

  btr_interp u_red (
    .clk    (clk),
    .step   (step),
    .sample (signed'(model_rd[MW-1 -: SAMPLE_W])),
    .fx     (fx),
    .fy     (fy),
    .value  (red_val)
  );

  btr_interp u_green (
    .clk    (clk),
    .step   (step),
    .sample (signed'(model_rd[MW-SAMPLE_W-1 -: SAMPLE_W])),
    .fx     (fx),
    .fy     (fy),
    .value  (green_val)
  );

  btr_interp u_blue (
    .clk    (clk),
    .step   (step),
    .sample (signed'(model_rd[SAMPLE_W-1:0])),
    .fx     (fx),
    .fy     (fy),
    .value  (blue_val)
  );

  // Result register: load when empty or being drained, else hold
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (pix.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_red   <= red_val;
      out_green <= green_val;
      out_blue  <= blue_val;
      out_alpha <= alpha_ok ? alpha_rd : '0;
    end
  end

  assign pix.valid     = out_valid;
  assign pix.red_out   = out_red;
  assign pix.green_out = out_green;
  assign pix.blue_out  = out_blue;
  assign pix.alpha_out = out_alpha;

  // Checks
  a_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(model_we && model_re))
    else $error("model memory written and read in one cycle");

  a_read_starts: assert property (@(posedge clk) disable iff (rst)
    cmd_xfer && cmd.action == ACT_READ |=> state == ST_CLAMP)
    else $error("read transfer did not start the sequencer");

  a_neighbors: assert property (@(posedge clk) disable iff (rst)
    state == ST_HORZ |-> (x1 == x0 || x1 == x0 + 1'b1) && (y1 == y0 || y1 == y0 + 1'b1) &&
                         fx < SIXTH && fy < SIXTH)
    else $error("neighbor pair or weight out of range");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && out_load |=> pix.valid && state == ST_IDLE)
    else $error("finished read did not reach the result register");

endmodule

// ===== src/btr_interp.sv =====
// One color channel: bilinear blend in 1/36 units, scale to a byte, round and clamp.
module btr_interp (
  input  logic                                clk,
  input  btr_pkg::btr_step_t                  step,
  input  logic signed [btr_pkg::SAMPLE_W-1:0] sample,
  input  logic [btr_pkg::FRAC_W-1:0]          fx,
  input  logic [btr_pkg::FRAC_W-1:0]          fy,
  output logic [btr_pkg::BYTE_W-1:0]          value
);
  import btr_pkg::*;

  localparam int H_W        = SAMPLE_W + 5;
  localparam int V_W        = SAMPLE_W + 8;
  localparam int N_W        = SAMPLE_W + 15;
  localparam int ROUND_DEN  = 36 * ONE_Q;
  localparam int ROUND_HALF = ROUND_DEN / 2;
  localparam int DEN_SHIFT  = $clog2(ONE_Q) + 2;
  localparam int DEN_ODD    = ROUND_DEN >> DEN_SHIFT;
  localparam int SAT_LIMIT  = (BYTE_MAX + 1) * ROUND_DEN;
  localparam int NQ_W       = $clog2(SAT_LIMIT >> DEN_SHIFT);
  localparam int DIV9_SHIFT = 13;
  localparam int DIV9_RECIP = (1 << DIV9_SHIFT) / DEN_ODD;
  localparam int P9_W       = NQ_W + DIV9_SHIFT;

  logic signed [SAMPLE_W-1:0] a, b, c;
  logic signed [H_W-1:0]      top, bot;
  logic signed [V_W-1:0]      v36;
  logic signed [N_W-1:0]      num;
  logic                       pos;
  logic                       sat;
  logic [NQ_W-1:0]            nq;
  logic [BYTE_W-1:0]          qraw;

  logic signed [H_W-1:0] a_x, b_x, c_x, d_x, fx_s;
  logic signed [V_W-1:0] top_x, bot_x, fy_s;
  logic [N_W-1:0]        n_sum;
  logic [NQ_W-1:0]       nq_next;
  logic [P9_W-1:0]       prod9;
  logic [NQ_W-1:0]       rem9;
  logic [BYTE_W-1:0]     q_fix;

  assign a_x   = H_W'(a);
  assign b_x   = H_W'(b);
  assign c_x   = H_W'(c);
  assign d_x   = H_W'(sample);
  assign fx_s  = H_W'(signed'({1'b0, fx}));
  assign top_x = V_W'(top);
  assign bot_x = V_W'(bot);
  assign fy_s  = V_W'(signed'({1'b0, fy}));

  // Round half up on the positive side only; non-positive values end at zero.
  assign n_sum   = unsigned'(num) + N_W'(ROUND_HALF);
  assign nq_next = n_sum[DEN_SHIFT +: NQ_W];
  assign prod9   = P9_W'(nq_next) * P9_W'(DIV9_RECIP);

  always_ff @(posedge clk) begin
    if (step.load_a) a <= sample;
    if (step.load_b) b <= sample;
    if (step.load_c) c <= sample;
    if (step.horz) begin
      top <= a_x * H_W'(SIXTH) + (b_x - a_x) * fx_s;
      bot <= c_x * H_W'(SIXTH) + (d_x - c_x) * fx_s;
    end
    if (step.vert) v36 <= top_x * V_W'(SIXTH) + (bot_x - top_x) * fy_s;
    if (step.scale) num <= N_W'(v36) * N_W'(BYTE_MAX);
    if (step.div) begin
      pos  <= (num > 0);
      sat  <= (n_sum >= N_W'(SAT_LIMIT));
      nq   <= nq_next;
      qraw <= prod9[DIV9_SHIFT +: BYTE_W];
    end
  end

  // Reciprocal estimate may fall one short of the quotient.
  assign rem9  = nq - NQ_W'(int'(qraw) * DEN_ODD);
  assign q_fix = (rem9 >= NQ_W'(DEN_ODD)) ? qraw + 1'b1 : qraw;
  assign value = !pos ? '0 : (sat ? BYTE_W'(BYTE_MAX) : q_fix);

endmodule

// ===== test/tb_bilinear_tile_resampler.sv =====
// Self-checking testbench for the bilinear tile resampler: random stimulus, predictor, scoreboard.
module tb_bilinear_tile_resampler;
  import btr_pkg::*;

  // The command field has one code that the block does nothing with.
  localparam logic [ACT_W-1:0] ACT_NOP = 2'd3;

  // The blend works in 1/36 of a sample and one sample unit is ONE_Q.
  localparam int ROUND_DEN     = SIXTH * SIXTH * ONE_Q;
  // Leave some margin for a read still in the block before a register write.
  localparam int SETTLE_CYCLES = 16;
  // Cycles with no transfer on any channel before the run is declared hung.
  localparam int STALL_LIMIT   = 3000;
  // Memory writes and reads queued per random phase; ten phases in all.
  localparam int PHASE_ITEMS   = 95;

  typedef struct {
    logic [ACT_W-1:0]           action;
    logic [POS_W-1:0]           x;
    logic [POS_W-1:0]           y;
    logic signed [SAMPLE_W-1:0] red;
    logic signed [SAMPLE_W-1:0] green;
    logic signed [SAMPLE_W-1:0] blue;
    logic [BYTE_W-1:0]          alpha;
  } cmd_item_t;

  typedef struct {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] alpha;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  btr_cfg_if cfg_ch ();
  btr_cmd_if cmd_ch ();
  btr_pix_if pix_ch ();

  bilinear_tile_resampler u_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .cmd (cmd_ch),
    .pix (pix_ch)
  );

  // Commands waiting for the command port, and the one currently offered.
  cmd_item_t cmd_pending_q[$];
  cmd_item_t cmd_cur;
  bit        cmd_hold = 1'b0;

  // Pixels the block owes, oldest first.
  pixel_t pixel_expect_q[$];
  pixel_t pixel_want;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;

  // Register values as last written, already cut to their widths.
  int scale_reg, width_reg, height_reg, left_reg, top_reg;

  // Predicted memory contents, updated as commands transfer.
  logic signed [SAMPLE_W-1:0] red_mem[int];
  logic signed [SAMPLE_W-1:0] green_mem[int];
  logic signed [SAMPLE_W-1:0] blue_mem[int];
  logic [BYTE_W-1:0]          alpha_mem[int];

  // Entries that the queued commands will have written by the time they drain.
  // Reads are only queued once every entry they touch is in here.
  bit model_filled[int];
  bit alpha_filled[int];

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Scale codes outside 2..4 saturate to the nearest legal scale.
  function automatic int eff_scale();
    if (scale_reg < 2) return 2;
    if (scale_reg > 4) return 4;
    return scale_reg;
  endfunction

  // Tile lengths of zero act as one; lengths past the memory act as its size.
  function automatic int eff_len(input int len);
    if (len < 1) return 1;
    if (len > MODEL_DIM) return MODEL_DIM;
    return len;
  endfunction

  // Map an output position onto the model grid in sixths, clamp to the tile, and
  // split into the two neighbors and the weight of the second one.
  function automatic void map_axis(input int pos, input int offset, input int len,
                                   output int first, output int second, output int frac);
    int c;
    int hi;
    // (24*pos + 12)/scale is the pixel center in sixths of a model pixel; the
    // division is exact for every legal scale.
    c = SIXTH * offset + ((24 * pos + 12) / eff_scale()) * (MODEL_SCALE / 4) - 3;
    hi = SIXTH * (len - 1);
    if (c < 0) c = 0;
    if (c > hi) c = hi;
    first = c / SIXTH;
    frac = c % SIXTH;
    second = (first + 1 < len) ? first + 1 : len - 1;
  endfunction

  // Blend four Q4.12 samples horizontally, then vertically, in exact sixths,
  // then scale to a byte, round half away from zero and clamp.
  function automatic logic [BYTE_W-1:0] blend_byte(input logic signed [SAMPLE_W-1:0] s00,
                                                   input logic signed [SAMPLE_W-1:0] s01,
                                                   input logic signed [SAMPLE_W-1:0] s10,
                                                   input logic signed [SAMPLE_W-1:0] s11,
                                                   input int fx, input int fy);
    longint a, b, c, d;
    longint upper, lower, v36, num, q;
    a = s00;
    b = s01;
    c = s10;
    d = s11;
    upper = SIXTH * a + (b - a) * fx;
    lower = SIXTH * c + (d - c) * fx;
    v36 = SIXTH * upper + (lower - upper) * fy;
    num = v36 * BYTE_MAX;
    // Anything at or below zero lands on zero after rounding and clamping.
    if (num <= 0) return '0;
    q = (num + ROUND_DEN / 2) / ROUND_DEN;
    if (q > BYTE_MAX) q = BYTE_MAX;
    return q[BYTE_W-1:0];
  endfunction

  // Advance the predicted state by one transferred command.
  function automatic void apply_item(input cmd_item_t it);
    int x0, x1, fx, y0, y1, fy;
    int i00, i01, i10, i11;
    int sx, sy, idx;
    pixel_t px;
    case (it.action)
      ACT_WRITE_MODEL: begin
        idx = int'(it.y) * MODEL_DIM + int'(it.x);
        red_mem[idx] = it.red;
        green_mem[idx] = it.green;
        blue_mem[idx] = it.blue;
      end
      ACT_WRITE_ALPHA: begin
        // Alpha writes past the source memory are dropped.
        if (it.x < SOURCE_DIM && it.y < SOURCE_DIM)
          alpha_mem[int'(it.y) * SOURCE_DIM + int'(it.x)] = it.alpha;
      end
      ACT_READ: begin
        map_axis(it.x, left_reg, eff_len(width_reg), x0, x1, fx);
        map_axis(it.y, top_reg, eff_len(height_reg), y0, y1, fy);
        i00 = y0 * MODEL_DIM + x0;
        i01 = y0 * MODEL_DIM + x1;
        i10 = y1 * MODEL_DIM + x0;
        i11 = y1 * MODEL_DIM + x1;
        px.red = blend_byte(red_mem[i00], red_mem[i01], red_mem[i10], red_mem[i11], fx, fy);
        px.green = blend_byte(green_mem[i00], green_mem[i01], green_mem[i10], green_mem[i11],
                              fx, fy);
        px.blue = blend_byte(blue_mem[i00], blue_mem[i01], blue_mem[i10], blue_mem[i11],
                             fx, fy);
        // Alpha comes from the nearest source pixel, or zero past the source memory.
        sx = int'(it.x) / eff_scale();
        sy = int'(it.y) / eff_scale();
        if (sx < SOURCE_DIM && sy < SOURCE_DIM)
          px.alpha = alpha_mem[sy * SOURCE_DIM + sx];
        else
          px.alpha = '0;
        pixel_expect_q.insert(pixel_expect_q.size(), px);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  // Mostly samples between a little below zero and a little above one, so that
  // results land inside the byte range; now and then any 16-bit value.
  function automatic int rand_sample();
    int v;
    if ($urandom_range(7) == 0) return $urandom_range(65535);
    v = $urandom_range(5120);
    return v - 512;
  endfunction

  // Queue one command. Return 1 when it writes a memory or reads a pixel, so that
  // commands the block ignores do not count toward a phase.
  function automatic int queue_cmd(input logic [ACT_W-1:0] act, input int x, input int y,
                                   input int r, input int g, input int b, input int a);
    cmd_item_t it;
    int counted;
    it.action = act;
    it.x = x[POS_W-1:0];
    it.y = y[POS_W-1:0];
    it.red = r[SAMPLE_W-1:0];
    it.green = g[SAMPLE_W-1:0];
    it.blue = b[SAMPLE_W-1:0];
    it.alpha = a[BYTE_W-1:0];
    counted = 1;
    case (act)
      ACT_WRITE_MODEL: model_filled[y * MODEL_DIM + x] = 1'b1;
      ACT_WRITE_ALPHA: begin
        if (x < SOURCE_DIM && y < SOURCE_DIM)
          alpha_filled[y * SOURCE_DIM + x] = 1'b1;
        else
          counted = 0;
      end
      ACT_READ: ;
      default: counted = 0;
    endcase
    cmd_pending_q.insert(cmd_pending_q.size(), it);
    return counted;
  endfunction

  // Queue a pixel read, preceded by writes of any neighbor or alpha entry it
  // would touch that nothing has written yet.
  function automatic int queue_read(input int x, input int y);
    int col[2];
    int row[2];
    int fx, fy, n, sx, sy;
    map_axis(x, left_reg, eff_len(width_reg), col[0], col[1], fx);
    map_axis(y, top_reg, eff_len(height_reg), row[0], row[1], fy);
    n = 0;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        if (!model_filled.exists(row[i] * MODEL_DIM + col[j]))
          n += queue_cmd(ACT_WRITE_MODEL, col[j], row[i], rand_sample(), rand_sample(),
                         rand_sample(), $urandom_range(255));
      end
    end
    sx = x / eff_scale();
    sy = y / eff_scale();
    if (sx < SOURCE_DIM && sy < SOURCE_DIM && !alpha_filled.exists(sy * SOURCE_DIM + sx))
      n += queue_cmd(ACT_WRITE_ALPHA, sx, sy, $urandom_range(65535), $urandom_range(65535),
                     $urandom_range(65535), $urandom_range(255));
    // Sample and alpha fields of a read are don't-care; fill them at random.
    n += queue_cmd(ACT_READ, x, y, $urandom_range(65535), $urandom_range(65535),
                   $urandom_range(65535), $urandom_range(255));
    return n;
  endfunction

  // One random phase under the current register settings: mostly write-then-read
  // sequences, with loose writes, dropped alpha writes and unused codes mixed in.
  function automatic void fill_phase(input int target);
    int n, w, h, s, pick, x, y, xmax, ymax;
    s = eff_scale();
    w = eff_len(width_reg);
    h = eff_len(height_reg);
    // Output positions that still fall inside the tile, roughly.
    xmax = (w * s) / 4 + 1;
    ymax = (h * s) / 4 + 1;
    if (xmax > MODEL_DIM - 1) xmax = MODEL_DIM - 1;
    if (ymax > MODEL_DIM - 1) ymax = MODEL_DIM - 1;
    n = 0;
    while (n < target) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        // Most reads inside the tile; the rest anywhere, to hit edge clamping
        // and alpha reads past the source memory.
        x = ($urandom_range(9) < 7) ? $urandom_range(xmax) : $urandom_range(MODEL_DIM - 1);
        y = ($urandom_range(9) < 7) ? $urandom_range(ymax) : $urandom_range(MODEL_DIM - 1);
        n += queue_read(x, y);
      end else if (pick < 82) begin
        n += queue_cmd(ACT_WRITE_MODEL, $urandom_range(w - 1), $urandom_range(h - 1),
                       rand_sample(), rand_sample(), rand_sample(), $urandom_range(255));
      end else if (pick < 95) begin
        x = ($urandom_range(3) != 0) ? $urandom_range(SOURCE_DIM - 1)
                                     : $urandom_range(MODEL_DIM - 1);
        y = ($urandom_range(3) != 0) ? $urandom_range(SOURCE_DIM - 1)
                                     : $urandom_range(MODEL_DIM - 1);
        n += queue_cmd(ACT_WRITE_ALPHA, x, y, $urandom_range(65535), $urandom_range(65535),
                       $urandom_range(65535), $urandom_range(255));
      end else begin
        void'(queue_cmd(ACT_NOP, $urandom_range(MODEL_DIM - 1), $urandom_range(MODEL_DIM - 1),
                        $urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                        $urandom_range(255)));
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Register writes and phase control
  // ---------------------------------------------------------------------------

  // Offer one register write, hold it until it transfers, then drop valid.
  task automatic write_reg(input btr_reg_t idx, input int value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_ZOOM:         scale_reg = value & ((1 << SCALE_W) - 1);
      CFG_MODEL_WIDTH:  width_reg = value & ((1 << LEN_W) - 1);
      CFG_MODEL_HEIGHT: height_reg = value & ((1 << LEN_W) - 1);
      CFG_LEFT_OFFSET:  left_reg = value & ((1 << OFF_W) - 1);
      CFG_TOP_OFFSET:   top_reg = value & ((1 << OFF_W) - 1);
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic configure(input int scale, input int width, input int height,
                           input int left, input int top);
    write_reg(CFG_ZOOM, scale);
    write_reg(CFG_MODEL_WIDTH, width);
    write_reg(CFG_MODEL_HEIGHT, height);
    write_reg(CFG_LEFT_OFFSET, left);
    write_reg(CFG_TOP_OFFSET, top);
  endtask

  // Wait until every queued command has transferred and every owed pixel has
  // arrived, then give the block time to finish a trailing write.
  task automatic settle();
    while (cmd_pending_q.size() != 0 || cmd_hold || pixel_expect_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Command driver
  // ---------------------------------------------------------------------------

  // Offer the next command at the falling edge; hold it until it transfers.
  always @(negedge clk) begin
    if (!rst && !cmd_hold) begin
      if (cmd_pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd_cur = cmd_pending_q.pop_front();
        cmd_hold = 1'b1;
        cmd_ch.valid <= 1'b1;
        cmd_ch.action <= cmd_cur.action;
        cmd_ch.pos_x <= cmd_cur.x;
        cmd_ch.pos_y <= cmd_cur.y;
        cmd_ch.red_in <= cmd_cur.red;
        cmd_ch.green_in <= cmd_cur.green;
        cmd_ch.blue_in <= cmd_cur.blue;
        cmd_ch.alpha_in <= cmd_cur.alpha;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // A command transfers here; advance the predictor with it.
  always @(posedge clk) begin
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      cmd_hold = 1'b0;
      apply_item(cmd_cur);
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel monitor and scoreboard
  // ---------------------------------------------------------------------------

  // Stall the result channel at random.
  always @(negedge clk) begin
    pix_ch.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic check_byte(input string field, input logic [BYTE_W-1:0] want,
                            input logic [BYTE_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    end
  endtask

  // Compare each transferred pixel with the oldest one owed.
  always @(posedge clk) begin
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      if (pixel_expect_q.size() == 0) begin
        mismatches++;
        $display("%0t: pixel with none expected: expected none got r=%0d g=%0d b=%0d a=%0d",
                 $time, pix_ch.red_out, pix_ch.green_out, pix_ch.blue_out, pix_ch.alpha_out);
      end else begin
        pixel_want = pixel_expect_q.pop_front();
        check_byte("red_out", pixel_want.red, pix_ch.red_out);
        check_byte("green_out", pixel_want.green, pix_ch.green_out);
        check_byte("blue_out", pixel_want.blue, pix_ch.blue_out);
        check_byte("alpha_out", pixel_want.alpha, pix_ch.alpha_out);
      end
    end
  end

  // Watchdog: end the run when no channel has moved for too long.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (pix_ch.valid && pix_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL bilinear_tile_resampler");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    // Register values after reset.
    scale_reg = 4;
    width_reg = MODEL_DIM;
    height_reg = MODEL_DIM;
    left_reg = 0;
    top_reg = 0;

    // Every input known from time zero.
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_ZOOM;
    cfg_ch.data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.action = ACT_WRITE_MODEL;
    cmd_ch.pos_x = '0;
    cmd_ch.pos_y = '0;
    cmd_ch.red_in = '0;
    cmd_ch.green_in = '0;
    cmd_ch.blue_in = '0;
    cmd_ch.alpha_in = '0;
    pix_ch.ready = 1'b0;

    send_idle_pct = 29;
    recv_idle_pct = 86;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, under the reset settings (scale 4, whole tile, no offsets).
    // At scale 4 every pixel center lands on a model pixel, so the first
    // neighbor alone decides the value.
    // Red 2048 sits exactly halfway between two bytes and must round up;
    // green -2048 must clamp to zero; blue full scale must clamp to 255.
    void'(queue_cmd(ACT_WRITE_MODEL, 0, 0, 2048, -2048, 32767, 0));
    void'(queue_cmd(ACT_WRITE_MODEL, 1, 0, -32768, 4096, 0, 0));
    void'(queue_cmd(ACT_WRITE_MODEL, 0, 1, 0, 4095, 1, 0));
    void'(queue_cmd(ACT_WRITE_MODEL, 1, 1, 32767, -1, 9, 0));
    void'(queue_cmd(ACT_WRITE_ALPHA, 0, 0, 0, 0, 0, 255));
    void'(queue_cmd(ACT_WRITE_ALPHA, SOURCE_DIM - 1, SOURCE_DIM - 1, 0, 0, 0, 0));
    // Alpha write past the source memory: dropped.
    void'(queue_cmd(ACT_WRITE_ALPHA, MODEL_DIM - 1, MODEL_DIM - 1, -1, -1, -1, 8'hAA));
    // Unused command code: no effect, no result.
    void'(queue_cmd(ACT_NOP, MODEL_DIM - 1, MODEL_DIM - 1, -1, -1, -1, 255));
    void'(queue_read(0, 0));
    // Far corner: both neighbors are held at the last row and column.
    void'(queue_cmd(ACT_WRITE_MODEL, MODEL_DIM - 1, MODEL_DIM - 1, 4096, -32768, 1234, 255));
    void'(queue_read(MODEL_DIM - 1, MODEL_DIM - 1));
    void'(queue_read(1, 0));
    void'(queue_read(0, 1));
    void'(queue_read(2, 2));
    settle();

    // Random phases. Each one rewrites all five registers, covering both ends of the
    // scale, width and offset ranges, and codes outside the meaningful ranges.
    for (int p = 0; p < 10; p++) begin
      if (p < 3) begin
        send_idle_pct = 29;
        recv_idle_pct = 86;
      end else if (p < 7) begin
        send_idle_pct = 86;
        recv_idle_pct = 29;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: configure(2, 8, 8, 0, 0);
        1: configure(3, 16, 5, 3, 1);
        2: configure(4, 1023, 1, 511, 0);
        3: configure(0, 0, 512, 0, 511);
        4: configure(7, 1, 600, 0, 0);
        5: configure(1, 512, 3, 100, 2);
        6: configure(5, 6, 7, 2, 2);
        7: configure(3, 4, 4, 0, 0);
        default: configure($urandom_range(7), $urandom_range(20, 1), $urandom_range(20, 1),
                           $urandom_range(4), $urandom_range(4));
      endcase
      fill_phase(PHASE_ITEMS);
      settle();
    end

    if (mismatches == 0) begin
      $display("PASS bilinear_tile_resampler");
    end else begin
      $display("FAIL bilinear_tile_resampler");
    end
    $finish;
  end

endmodule
